// ===== hdl/ipv4_tcp_udp_header_generator_defines.svh =====
// assertion helpers shared by the rtl files
`ifndef IPV4_TCP_UDP_HEADER_GENERATOR_DEFINES_SVH
`define IPV4_TCP_UDP_HEADER_GENERATOR_DEFINES_SVH

// check on every clock edge once reset is released
`define IPHG_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// check that prop holds in the cycle after the trigger
`define IPHG_ASSERT_NEXT(name, trig, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
        else $error(msg);

`endif

// ===== hdl/iphg_pkg.sv =====
package iphg_pkg;

    localparam logic [3:0] REG_SRC_ADDR  = 4'd0;
    localparam logic [3:0] REG_DST_ADDR  = 4'd1;
    localparam logic [3:0] REG_ORIG_PORT = 4'd2;
    localparam logic [3:0] REG_DST_PORT  = 4'd3;
    localparam logic [3:0] REG_SEQ_NUM   = 4'd4;
    localparam logic [3:0] REG_ACK_NUM   = 4'd5;
    localparam logic [3:0] REG_TCP_FLAGS = 4'd6;
    localparam logic [3:0] REG_IS_TCP    = 4'd7;

    localparam logic [7:0]  IP_VER_IHL     = 8'h45;
    localparam logic [7:0]  IP_TTL         = 8'd255;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;
    localparam logic [15:0] TCP_IP_ID      = 16'd8;
    localparam logic [7:0]  TCP_DATA_OFS   = 8'h50;
    localparam logic [15:0] TCP_WINDOW     = 16'h16d0;
    localparam logic [15:0] TCP_HDR_LEN    = 16'd20;
    localparam logic [15:0] UDP_HDR_LEN    = 16'd8;
    localparam logic [15:0] TCP_PKT_HDR    = 16'd40;
    localparam logic [15:0] UDP_PKT_HDR    = 16'd28;
    localparam logic [5:0]  TCP_LAST_IDX   = 6'd39;
    localparam logic [5:0]  UDP_LAST_IDX   = 6'd27;
    localparam logic [3:0]  CALC_LAST_STEP = 4'd15;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;
    localparam int QUEUE_CNT_W = 2;

    typedef struct packed {
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] orig_port;
        logic [15:0] dst_port;
        logic [31:0] seq_num;
        logic [31:0] ack_num;
        logic [7:0]  tcp_flags;
        logic        is_tcp;
    } cfg_t;

    // packet summary handed from the front to the back
    typedef struct packed {
        logic [15:0] sum;
        logic [7:0]  held;
        logic        odd;
        logic [15:0] count;
        logic        ovf;
    } desc_t;

    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

    function automatic logic [15:0] total_len(input cfg_t cfg, input logic [15:0] count);
        return count + (cfg.is_tcp ? TCP_PKT_HDR : UDP_PKT_HDR);
    endfunction

    function automatic logic [15:0] ip_word(input logic [3:0] k, input cfg_t cfg,
                                            input logic [15:0] count);
        logic [15:0] w;
        unique case (k)
            4'd0:    w = {IP_VER_IHL, 8'd0};
            4'd1:    w = total_len(cfg, count);
            4'd2:    w = cfg.is_tcp ? TCP_IP_ID : 16'd0;
            4'd3:    w = {IP_TTL, (cfg.is_tcp ? PROTO_TCP : PROTO_UDP)};
            4'd4:    w = cfg.src_addr[31:16];
            4'd5:    w = cfg.src_addr[15:0];
            4'd6:    w = cfg.dst_addr[31:16];
            4'd7:    w = cfg.dst_addr[15:0];
            default: w = 16'd0;
        endcase
        return w;
    endfunction

    function automatic logic [15:0] tcp_word(input logic [3:0] k, input cfg_t cfg,
                                             input desc_t d);
        logic [15:0] w;
        unique case (k)
            4'd0:    w = cfg.src_addr[31:16];
            4'd1:    w = cfg.src_addr[15:0];
            4'd2:    w = cfg.dst_addr[31:16];
            4'd3:    w = cfg.dst_addr[15:0];
            4'd4:    w = {8'd0, PROTO_TCP};
            4'd5:    w = d.count + TCP_HDR_LEN;
            4'd6:    w = cfg.orig_port;
            4'd7:    w = cfg.dst_port;
            4'd8:    w = cfg.seq_num[31:16];
            4'd9:    w = cfg.seq_num[15:0];
            4'd10:   w = cfg.ack_num[31:16];
            4'd11:   w = cfg.ack_num[15:0];
            4'd12:   w = {TCP_DATA_OFS, cfg.tcp_flags};
            4'd13:   w = TCP_WINDOW;
            4'd14:   w = d.sum;
            default: w = d.odd ? {d.held, 8'd0} : 16'd0;
        endcase
        return w;
    endfunction

    function automatic logic [7:0] hdr_byte(input logic [5:0] idx, input cfg_t cfg,
                                            input logic [15:0] count,
                                            input logic [15:0] ip_ck,
                                            input logic [15:0] tcp_ck);
        logic [15:0] tl;
        logic [15:0] ul;
        logic [7:0]  b;
        tl = total_len(cfg, count);
        ul = count + UDP_HDR_LEN;
        unique case (idx)
            6'd0:    b = IP_VER_IHL;
            6'd2:    b = tl[15:8];
            6'd3:    b = tl[7:0];
            6'd5:    b = cfg.is_tcp ? TCP_IP_ID[7:0] : 8'd0;
            6'd8:    b = IP_TTL;
            6'd9:    b = cfg.is_tcp ? PROTO_TCP : PROTO_UDP;
            6'd10:   b = ip_ck[15:8];
            6'd11:   b = ip_ck[7:0];
            6'd12:   b = cfg.src_addr[31:24];
            6'd13:   b = cfg.src_addr[23:16];
            6'd14:   b = cfg.src_addr[15:8];
            6'd15:   b = cfg.src_addr[7:0];
            6'd16:   b = cfg.dst_addr[31:24];
            6'd17:   b = cfg.dst_addr[23:16];
            6'd18:   b = cfg.dst_addr[15:8];
            6'd19:   b = cfg.dst_addr[7:0];
            6'd20:   b = cfg.orig_port[15:8];
            6'd21:   b = cfg.orig_port[7:0];
            6'd22:   b = cfg.dst_port[15:8];
            6'd23:   b = cfg.dst_port[7:0];
            6'd24:   b = cfg.is_tcp ? cfg.seq_num[31:24] : ul[15:8];
            6'd25:   b = cfg.is_tcp ? cfg.seq_num[23:16] : ul[7:0];
            6'd26:   b = cfg.is_tcp ? cfg.seq_num[15:8] : 8'd0;
            6'd27:   b = cfg.is_tcp ? cfg.seq_num[7:0] : 8'd0;
            6'd28:   b = cfg.ack_num[31:24];
            6'd29:   b = cfg.ack_num[23:16];
            6'd30:   b = cfg.ack_num[15:8];
            6'd31:   b = cfg.ack_num[7:0];
            6'd32:   b = TCP_DATA_OFS;
            6'd33:   b = cfg.tcp_flags;
            6'd34:   b = TCP_WINDOW[15:8];
            6'd35:   b = TCP_WINDOW[7:0];
            6'd36:   b = tcp_ck[15:8];
            6'd37:   b = tcp_ck[7:0];
            default: b = 8'd0;
        endcase
        return b;
    endfunction

endpackage

// ===== hdl/iphg_front.sv =====
module iphg_front #(
    parameter int MAX_PAYLOAD = 1460
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  logic [7:0]      payload_byte,
    input  logic            byte_present,
    input  logic            end_of_payload,
    output logic            push,
    output iphg_pkg::desc_t push_desc
);

    logic [15:0] sum_reg, sum_next;
    logic [7:0]  held_reg, held_next;
    logic        odd_reg, odd_next;
    logic [15:0] count_reg, count_next;
    logic        ovf_reg, ovf_next;

    always_comb
    begin
        sum_next   = sum_reg;
        held_next  = held_reg;
        odd_next   = odd_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (byte_present)
        begin
            if (count_reg >= 16'(MAX_PAYLOAD))
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                if (odd_reg)
                begin
                    sum_next  = iphg_pkg::oc_add(sum_reg, {held_reg, payload_byte});
                    held_next = 8'd0;
                    odd_next  = 1'b0;
                end
                else
                begin
                    held_next = payload_byte;
                    odd_next  = 1'b1;
                end
                count_next = count_reg + 16'd1;
            end
        end
    end

    assign push = accept && end_of_payload;
    assign push_desc = '{sum: sum_next, held: held_next, odd: odd_next,
                         count: count_next, ovf: ovf_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            held_reg  <= '0;
            odd_reg   <= 1'b0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (push)
        begin
            sum_reg   <= '0;
            held_reg  <= '0;
            odd_reg   <= 1'b0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (accept)
        begin
            sum_reg   <= sum_next;
            held_reg  <= held_next;
            odd_reg   <= odd_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule

// ===== hdl/iphg_queue.sv =====
`include "ipv4_tcp_udp_header_generator_defines.svh"

module iphg_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  iphg_pkg::desc_t push_desc,
    input  logic            pop,
    output iphg_pkg::desc_t head,
    output logic            full,
    output logic            empty
);

    iphg_pkg::desc_t entry_reg [iphg_pkg::QUEUE_DEPTH];
    logic [iphg_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [iphg_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [iphg_pkg::QUEUE_CNT_W-1:0] cnt_reg, cnt_next;

    assign full  = (cnt_reg == iphg_pkg::QUEUE_CNT_W'(iphg_pkg::QUEUE_DEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + iphg_pkg::QUEUE_CNT_W'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - iphg_pkg::QUEUE_CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_desc;
    end

    `IPHG_ASSERT(a_queue_no_overrun, !(push && full), "summary pushed into full queue")
    `IPHG_ASSERT(a_queue_no_underrun, !(pop && empty), "summary popped from empty queue")

endmodule

// ===== hdl/iphg_back.sv =====
`include "ipv4_tcp_udp_header_generator_defines.svh"

module iphg_back (
    input  logic            clk,
    input  logic            rst_n,
    input  iphg_pkg::cfg_t  cfg,
    input  iphg_pkg::desc_t head,
    input  logic            empty,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [7:0]      header_byte,
    output logic            header_last,
    output logic            length_overflow
);

    typedef enum logic [2:0] {
        B_IDLE = 3'b001,
        B_CALC = 3'b010,
        B_EMIT = 3'b100
    } back_state_t;

    back_state_t     state_reg, state_next;
    iphg_pkg::desc_t desc_reg;
    logic [3:0]      step_reg, step_next;
    logic [5:0]      idx_reg, idx_next;
    logic [15:0]     ip_acc_reg, ip_acc_next;
    logic [15:0]     tcp_acc_reg, tcp_acc_next;
    logic            out_valid_reg, out_valid_next;
    logic [7:0]      out_byte_reg;
    logic            out_last_reg;
    logic            out_ovf_reg;
    logic            load;
    logic            is_last;
    logic [5:0]      last_idx;

    assign last_idx = cfg.is_tcp ? iphg_pkg::TCP_LAST_IDX : iphg_pkg::UDP_LAST_IDX;
    assign is_last  = (idx_reg == last_idx);
    assign load     = (state_reg == B_EMIT) && (!out_valid_reg || out_ready);
    assign pop      = (state_reg == B_IDLE) && !empty;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        idx_next       = idx_reg;
        ip_acc_next    = ip_acc_reg;
        tcp_acc_next   = tcp_acc_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!empty)
                begin
                    state_next   = B_CALC;
                    step_next    = '0;
                    ip_acc_next  = '0;
                    tcp_acc_next = '0;
                end
            end
            B_CALC:
            begin
                ip_acc_next  = iphg_pkg::oc_add(ip_acc_reg,
                    iphg_pkg::ip_word(step_reg, cfg, desc_reg.count));
                tcp_acc_next = iphg_pkg::oc_add(tcp_acc_reg,
                    iphg_pkg::tcp_word(step_reg, cfg, desc_reg));
                step_next    = step_reg + 4'd1;
                if (step_reg == iphg_pkg::CALC_LAST_STEP)
                begin
                    state_next = B_EMIT;
                    idx_next   = '0;
                end
            end
            B_EMIT:
            begin
                if (load)
                begin
                    out_valid_next = 1'b1;
                    idx_next       = idx_reg + 6'd1;
                    if (is_last)
                        state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            step_reg      <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ip_acc_reg  <= ip_acc_next;
        tcp_acc_reg <= tcp_acc_next;
        if (pop)
            desc_reg <= head;
        if (load)
        begin
            out_byte_reg <= iphg_pkg::hdr_byte(idx_reg, cfg, desc_reg.count,
                                               ~ip_acc_reg, ~tcp_acc_reg);
            out_last_reg <= is_last;
            out_ovf_reg  <= desc_reg.ovf;
        end
    end

    assign out_valid       = out_valid_reg;
    assign header_byte     = out_byte_reg;
    assign header_last     = out_last_reg;
    assign length_overflow = out_ovf_reg;

    `IPHG_ASSERT(a_emit_idx_bound, (state_reg != B_EMIT) || (idx_reg <= last_idx),
                 "header byte index past end of header")
    `IPHG_ASSERT_NEXT(a_last_ends_packet, load && is_last, state_reg == B_IDLE,
                      "back did not return to idle after last header byte")
    `IPHG_ASSERT_NEXT(a_pop_starts_calc, pop, (state_reg == B_CALC) && (step_reg == 4'd0),
                      "checksum pass did not start after queue pop")

endmodule

// ===== hdl/ipv4_tcp_udp_header_generator.sv =====
// IPv4 plus TCP/UDP header generator. Payload bytes come in on the slave stream, one per
// cycle with no stall while the summary queue has room; the payload is only summed and counted,
// never passed on. The item marked tlast hands the packet's summary to a two-deep queue and the
// front starts the next packet in the following cycle. The back side takes one summary at a
// time, folds the IPv4 and TCP checksums through two 16-bit end-around adders, one per
// checksum, then sends 40 (TCP) or 28 (UDP) header bytes, one per cycle while m_axis_tready
// is high. The front stalls only when two finished packets already wait in the queue.
// Configuration writes are always accepted and must only be made while no packet is in flight.
module ipv4_tcp_udp_header_generator #(
    parameter int MAX_PAYLOAD = 1460
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // payload_byte
    input  logic        s_axis_tuser,   // byte_present
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // header_byte
    output logic        m_axis_tuser,   // length_overflow
    output logic        m_axis_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    iphg_pkg::cfg_t  cfg_reg;
    iphg_pkg::desc_t push_desc;
    iphg_pkg::desc_t head;
    logic            push;
    logic            pop;
    logic            full;
    logic            empty;
    logic            in_accept;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !full;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.src_addr  <= '0;
            cfg_reg.dst_addr  <= '0;
            cfg_reg.orig_port <= '0;
            cfg_reg.dst_port  <= '0;
            cfg_reg.seq_num   <= '0;
            cfg_reg.ack_num   <= '0;
            cfg_reg.tcp_flags <= 8'h10;
            cfg_reg.is_tcp    <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                iphg_pkg::REG_SRC_ADDR:  cfg_reg.src_addr  <= cfg_data;
                iphg_pkg::REG_DST_ADDR:  cfg_reg.dst_addr  <= cfg_data;
                iphg_pkg::REG_ORIG_PORT: cfg_reg.orig_port <= cfg_data[15:0];
                iphg_pkg::REG_DST_PORT:  cfg_reg.dst_port  <= cfg_data[15:0];
                iphg_pkg::REG_SEQ_NUM:   cfg_reg.seq_num   <= cfg_data;
                iphg_pkg::REG_ACK_NUM:   cfg_reg.ack_num   <= cfg_data;
                iphg_pkg::REG_TCP_FLAGS: cfg_reg.tcp_flags <= cfg_data[7:0];
                iphg_pkg::REG_IS_TCP:    cfg_reg.is_tcp    <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    iphg_front #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (in_accept),
        .payload_byte   (s_axis_tdata),
        .byte_present   (s_axis_tuser),
        .end_of_payload (s_axis_tlast),
        .push           (push),
        .push_desc      (push_desc)
    );

    iphg_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .head      (head),
        .full      (full),
        .empty     (empty)
    );

    iphg_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .head            (head),
        .empty           (empty),
        .pop             (pop),
        .out_valid       (m_axis_tvalid),
        .out_ready       (m_axis_tready),
        .header_byte     (m_axis_tdata),
        .header_last     (m_axis_tlast),
        .length_overflow (m_axis_tuser)
    );

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PAYLOAD_LIMIT  = 1460;
    localparam int RANDOM_ITEMS   = 500;
    localparam int IDLE_GAP       = 16;
    localparam int TAIL_CYCLES    = 64;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int IP_CKSUM_WORD  = 5;
    localparam int REG_INDEX_MAX  = 15;

    typedef struct {
        logic [7:0] data;
        logic       present;
        logic       last;
    } payload_item_t;

    typedef struct {
        logic [7:0] data;
        logic       last;
        logic       ovf;
    } hdr_beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // payload_byte
    logic        s_axis_tuser = 1'b0;    // byte_present
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;           // header_byte
    logic        m_axis_tuser;           // length_overflow
    logic        m_axis_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [3:0]  cfg_index = 4'h0;
    logic [31:0] cfg_data = 32'h0000_0000;

    // shadow copy of the header registers
    logic [31:0] hdr_src_addr  = 32'h0000_0000;
    logic [31:0] hdr_dst_addr  = 32'h0000_0000;
    logic [15:0] hdr_orig_port = 16'h0000;
    logic [15:0] hdr_dst_port  = 16'h0000;
    logic [31:0] hdr_seq_num   = 32'h0000_0000;
    logic [31:0] hdr_ack_num   = 32'h0000_0000;
    logic [7:0]  hdr_tcp_flags = 8'h10;
    logic        hdr_is_tcp    = 1'b1;

    // running payload state of the packet in progress
    logic [15:0] pay_sum   = 16'h0000;
    logic [7:0]  pay_held  = 8'h00;
    logic        pay_odd   = 1'b0;
    logic [15:0] pay_count = 16'h0000;
    logic        pay_ovf   = 1'b0;

    payload_item_t payload_queue[$];
    hdr_beat_t     header_expect[$];
    payload_item_t drive_item;

    int          stim_items = 0;
    int          failures = 0;
    int          stall_cycles = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    logic [15:0] rx_pattern = '1;
    int          rx_phase = 0;

    ipv4_tcp_udp_header_generator #(
        .MAX_PAYLOAD(PAYLOAD_LIMIT)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

    // pseudo-header plus tcp header with the checksum field zero
    function automatic logic [15:0] tcp_header_sum(input logic [15:0] count);
        logic [15:0] words [14];
        logic [15:0] acc;
        words = '{hdr_src_addr[31:16], hdr_src_addr[15:0], hdr_dst_addr[31:16],
                  hdr_dst_addr[15:0], {8'h00, iphg_pkg::PROTO_TCP},
                  count + iphg_pkg::TCP_HDR_LEN,
                  hdr_orig_port, hdr_dst_port, hdr_seq_num[31:16], hdr_seq_num[15:0],
                  hdr_ack_num[31:16], hdr_ack_num[15:0],
                  {iphg_pkg::TCP_DATA_OFS, hdr_tcp_flags}, iphg_pkg::TCP_WINDOW};
        acc = 16'h0000;
        foreach (words[i])
            acc = ones_add(acc, words[i]);
        return acc;
    endfunction

    function automatic void emit_header();
        logic [15:0] hw[$];
        logic [15:0] acc;
        logic [15:0] body;
        hw.push_back({iphg_pkg::IP_VER_IHL, 8'h00});
        hw.push_back(pay_count + (hdr_is_tcp ? iphg_pkg::TCP_PKT_HDR
                                             : iphg_pkg::UDP_PKT_HDR));
        hw.push_back(hdr_is_tcp ? iphg_pkg::TCP_IP_ID : 16'h0000);
        hw.push_back(16'h0000);
        hw.push_back({iphg_pkg::IP_TTL,
                      (hdr_is_tcp ? iphg_pkg::PROTO_TCP : iphg_pkg::PROTO_UDP)});
        hw.push_back(16'h0000);
        hw.push_back(hdr_src_addr[31:16]);
        hw.push_back(hdr_src_addr[15:0]);
        hw.push_back(hdr_dst_addr[31:16]);
        hw.push_back(hdr_dst_addr[15:0]);
        acc = 16'h0000;
        foreach (hw[i])
            acc = ones_add(acc, hw[i]);
        hw[IP_CKSUM_WORD] = ~acc;
        hw.push_back(hdr_orig_port);
        hw.push_back(hdr_dst_port);
        if (hdr_is_tcp)
        begin
            // odd trailing byte is padded with a zero low byte
            body = pay_odd ? ones_add(pay_sum, {pay_held, 8'h00}) : pay_sum;
            hw.push_back(hdr_seq_num[31:16]);
            hw.push_back(hdr_seq_num[15:0]);
            hw.push_back(hdr_ack_num[31:16]);
            hw.push_back(hdr_ack_num[15:0]);
            hw.push_back({iphg_pkg::TCP_DATA_OFS, hdr_tcp_flags});
            hw.push_back(iphg_pkg::TCP_WINDOW);
            hw.push_back(~ones_add(tcp_header_sum(pay_count), body));
            hw.push_back(16'h0000);
        end
        else
        begin
            hw.push_back(pay_count + iphg_pkg::UDP_HDR_LEN);
            hw.push_back(16'h0000);
        end
        foreach (hw[i])
        begin
            header_expect.push_back(hdr_beat_t'{hw[i][15:8], 1'b0, pay_ovf});
            header_expect.push_back(hdr_beat_t'{hw[i][7:0], i == hw.size() - 1, pay_ovf});
        end
    endfunction

    function automatic void take_payload_item(input payload_item_t it);
        if (it.present)
        begin
            if (pay_count >= PAYLOAD_LIMIT)
                pay_ovf = 1'b1;
            else
            begin
                if (pay_odd)
                begin
                    pay_sum  = ones_add(pay_sum, {pay_held, it.data});
                    pay_odd  = 1'b0;
                    pay_held = 8'h00;
                end
                else
                begin
                    pay_held = it.data;
                    pay_odd  = 1'b1;
                end
                pay_count = pay_count + 16'd1;
            end
        end
        if (it.last)
        begin
            emit_header();
            pay_sum   = 16'h0000;
            pay_held  = 8'h00;
            pay_odd   = 1'b0;
            pay_count = 16'h0000;
            pay_ovf   = 1'b0;
        end
    endfunction

    // fill < 0 gives random bytes; without tail_byte the end rides on an empty item
    function automatic void push_packet(input int len, input bit tail_byte, input int fill,
                                        input bit noisy);
        payload_item_t it;
        for (int i = 0; i < len; i++)
        begin
            if (noisy && $urandom_range(0, 11) == 0)
                payload_queue.push_back(payload_item_t'{8'($urandom), 1'b0, 1'b0});
            it.data    = (fill < 0) ? 8'($urandom) : 8'(fill);
            it.present = 1'b1;
            it.last    = tail_byte && (i == len - 1);
            payload_queue.push_back(it);
        end
        if (!tail_byte || len == 0)
        begin
            payload_queue.push_back(payload_item_t'{8'($urandom), 1'b0, 1'b1});
            stim_items++;
        end
        stim_items += len;
    endfunction

    function automatic logic [31:0] pick_reg_value();
        case ($urandom_range(0, 9))
            0: return 32'h0000_0000;
            1: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    task automatic write_reg(input logic [3:0] idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            iphg_pkg::REG_SRC_ADDR:  hdr_src_addr  = value;
            iphg_pkg::REG_DST_ADDR:  hdr_dst_addr  = value;
            iphg_pkg::REG_ORIG_PORT: hdr_orig_port = value[15:0];
            iphg_pkg::REG_DST_PORT:  hdr_dst_port  = value[15:0];
            iphg_pkg::REG_SEQ_NUM:   hdr_seq_num   = value;
            iphg_pkg::REG_ACK_NUM:   hdr_ack_num   = value;
            iphg_pkg::REG_TCP_FLAGS: hdr_tcp_flags = value[7:0];
            iphg_pkg::REG_IS_TCP:    hdr_is_tcp    = value[0];
            default: ;
        endcase
    endtask

    task automatic write_all(input logic [31:0] value);
        for (int i = int'(iphg_pkg::REG_SRC_ADDR); i <= int'(iphg_pkg::REG_IS_TCP); i++)
            write_reg(4'(i), value);
    endtask

    task automatic randomize_regs();
        for (int i = int'(iphg_pkg::REG_SRC_ADDR); i <= int'(iphg_pkg::REG_IS_TCP); i++)
            if ($urandom_range(0, 1) == 1)
                write_reg(4'(i), pick_reg_value());
        if ($urandom_range(0, 3) == 0)
            write_reg(4'($urandom_range(int'(iphg_pkg::REG_IS_TCP) + 1, REG_INDEX_MAX)),
                      $urandom);
    endtask

    task automatic wait_idle(input int hold);
        while (payload_queue.size() != 0 || s_axis_tvalid || header_expect.size() != 0)
            @(posedge clk);
        repeat (hold) @(posedge clk);
    endtask

    // payload driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'h00;
            s_axis_tuser  <= 1'b0;
            s_axis_tlast  <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                take_payload_item(drive_item);
            if (!(s_axis_tvalid && !s_axis_tready))
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (payload_queue.size() != 0)
                begin
                    drive_item = payload_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= drive_item.data;
                    s_axis_tuser  <= drive_item.present;
                    s_axis_tlast  <= drive_item.last;
                    if (burst_left > 1)
                        burst_left--;
                    else if ($urandom_range(0, 3) == 0)
                    begin
                        burst_left = 200;
                        gap_left   = 0;
                    end
                    else
                    begin
                        burst_left = $urandom_range(1, 16);
                        gap_left   = $urandom_range(0, 10);
                    end
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    task automatic check_header_beat();
        hdr_beat_t want;
        if (header_expect.size() == 0)
        begin
            $error("header_byte: no transaction expected, actual %02h", m_axis_tdata);
            failures++;
        end
        else
        begin
            want = header_expect.pop_front();
            if (m_axis_tdata !== want.data)
            begin
                $error("header_byte: expected %02h, actual %02h", want.data, m_axis_tdata);
                failures++;
            end
            if (m_axis_tlast !== want.last)
            begin
                $error("header_last: expected %0b, actual %0b", want.last, m_axis_tlast);
                failures++;
            end
            if (m_axis_tuser !== want.ovf)
            begin
                $error("length_overflow: expected %0b, actual %0b", want.ovf, m_axis_tuser);
                failures++;
            end
        end
    endtask

    // header monitor with its own ready pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_header_beat();
            if (rx_phase == 0)
            begin
                case ($urandom_range(0, 3))
                    0: rx_pattern = '1;
                    1: rx_pattern = 16'h0001 << $urandom_range(0, 15);
                    default: rx_pattern = 16'($urandom) | 16'h0001;
                endcase
            end
            m_axis_tready <= rx_pattern[0];
            rx_pattern = {rx_pattern[0], rx_pattern[15:1]};
            rx_phase = (rx_phase + 1) % 64;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        int          phase_no;
        int          pkt_cnt;
        int          len;
        int          saved;
        logic [15:0] cancel_word;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // register reset values, empty payload and odd lengths
        push_packet(0, 1'b0, 0, 1'b0);
        push_packet(1, 1'b1, 8'hff, 1'b0);
        push_packet(3, 1'b0, 8'h00, 1'b0);
        wait_idle(IDLE_GAP);

        write_all(32'hffff_ffff);
        cfg_valid <= 1'b0;
        push_packet(2, 1'b1, 8'hff, 1'b0);
        wait_idle(IDLE_GAP);

        write_reg(iphg_pkg::REG_IS_TCP, 32'hffff_fffe);
        cfg_valid <= 1'b0;
        push_packet(0, 1'b0, 0, 1'b0);
        push_packet(1, 1'b1, 8'ha5, 1'b0);
        wait_idle(IDLE_GAP);

        write_all(32'h0000_0000);
        cfg_valid <= 1'b0;
        push_packet(2, 1'b1, 8'h00, 1'b0);
        wait_idle(IDLE_GAP);

        // unused register indexes must not disturb the header
        randomize_regs();
        write_reg(iphg_pkg::REG_IS_TCP, 32'h0000_0001);
        write_reg(4'(REG_INDEX_MAX), 32'hffff_ffff);
        write_reg(iphg_pkg::REG_IS_TCP + 4'd1, 32'h0000_0000);
        cfg_valid <= 1'b0;
        // payload word that cancels the header sum, so the tcp checksum comes out zero
        cancel_word = ~tcp_header_sum(16'd2);
        payload_queue.push_back(payload_item_t'{cancel_word[15:8], 1'b1, 1'b0});
        payload_queue.push_back(payload_item_t'{cancel_word[7:0], 1'b1, 1'b1});

        stim_items = 0;
        phase_no = 0;
        while (stim_items < RANDOM_ITEMS)
        begin
            wait_idle(IDLE_GAP);
            randomize_regs();
            cfg_valid <= 1'b0;
            phase_no++;
            saved = stim_items;
            case (phase_no)
                2: push_packet(PAYLOAD_LIMIT, 1'b1, -1, 1'b0);
                4: push_packet(PAYLOAD_LIMIT + 1, 1'b0, -1, 1'b0);
                6: push_packet(PAYLOAD_LIMIT + 10, 1'b1, -1, 1'b1);
                default: ;
            endcase
            stim_items = saved;
            pkt_cnt = $urandom_range(2, 8);
            repeat (pkt_cnt)
            begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 80)
                                                  : $urandom_range(0, 24);
                push_packet(len, 1'($urandom_range(0, 1)), -1, 1'b1);
            end
        end
        wait_idle(TAIL_CYCLES);

        if (failures == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/iphg_pkg.sv
hdl/iphg_front.sv
hdl/iphg_queue.sv
hdl/iphg_back.sv
hdl/ipv4_tcp_udp_header_generator.sv
tb/tb_top.sv
